// ===== design/chull_pkg.sv =====
// ----------------------------------------------------------------------------
// chull_pkg
// shared constants for the graham scan convex hull block
// ----------------------------------------------------------------------------
package chull_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int COORD_BITS_DEF = 16;
	localparam int VNUM_BITS      = 6;

endpackage

// ===== design/convex_hull_graham_scan.sv =====
// ----------------------------------------------------------------------------
// convex_hull_graham_scan
// convex hull of a point set by angular sort and graham scan, one multiplier
// ----------------------------------------------------------------------------
// channel  direction  handshake          payload
// input    in         valid / stall      point_x, point_y, set_end
// output   out        out_valid / out_stall  vertex_x, vertex_y, vertex_number,
//                                        final_vertex, dropped_points
//
// a point word is taken whenever valid is high while the block is loading
// the word with set_end holds the block for the anchor search, an insertion
// sort (one shared multiplier, single-port store read) and the scan of turn
// tests; each hull vertex is then read from the stack, read from the store,
// registered out, and held until out_stall is low
// reset clears the point count and returns to loading; no clearing pass
// ----------------------------------------------------------------------------
module convex_hull_graham_scan
	import chull_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         valid,
	output logic                         stall,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic                         set_end,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [COORD_BITS-1:0] vertex_x,
	output logic signed [COORD_BITS-1:0] vertex_y,
	output logic [VNUM_BITS-1:0]         vertex_number,
	output logic                         final_vertex,
	output logic                         dropped_points
);

	localparam int CB = COORD_BITS;
	localparam int IW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int D  = CB + 1;
	localparam int PW = 2 * D;
	localparam int SW = PW + 1;

	typedef enum logic [4:0] {
		S_LOAD, S_AN_RD, S_AN_CMP,
		S_SO_NEXT, S_SO_Q, S_SO_J, S_SO_IDX, S_SO_B,
		S_PR0, S_PR1, S_PR2, S_PR3, S_PR4, S_PR5, S_PR6,
		S_SC_INIT, S_SC_NEXT, S_SC_NIDX, S_SC_N, S_SC_TEST, S_SC_PIDX, S_SC_P,
		S_SC_CIDX, S_SC_C, S_SC_M0, S_SC_M1, S_SC_M2,
		S_EM_RD, S_EM_IDX, S_EM_DATA, S_EM_WAIT
	} state_t;

	state_t state_q;

	logic [2*CB-1:0] store_mem [MAX_POINTS];
	logic [IW-1:0]   sort_mem  [MAX_POINTS];
	logic [IW-1:0]   stack_mem [MAX_POINTS];

	logic [2*CB-1:0] st_rd_q;
	logic [IW-1:0]   so_rd_q, hs_rd_q;

	logic [CW-1:0] count_q, ii_q, nn_q, jj_q, depth_q;
	logic          ovf_q;
	logic [IW-1:0] anchor_q, bidx_q, nidx_q;

	logic signed [CB-1:0] apx_q, apy_q, qx_q, qy_q, px_q, py_q;
	logic signed [D-1:0]  da_x_q, da_y_q, db_x_q, db_y_q;
	logic signed [PW-1:0] prod_q;
	logic signed [SW-1:0] t_q, u_q;

	logic                 in_acc;
	logic [IW-1:0]        st_ra, so_ra, hs_ra, so_wa, hs_wa;
	logic [IW-1:0]        so_wd, hs_wd;
	logic                 so_we, hs_we;
	logic signed [D-1:0]  opa, opb, dax_adj, dbx_adj;
	logic signed [SW-1:0] prod_ext, lb;
	logic                 pr_done, pr_res, cw_flat;
	logic signed [CB-1:0] rd_x, rd_y;

	assign stall  = (state_q != S_LOAD);
	assign in_acc = valid && (state_q == S_LOAD);
	assign rd_x   = st_rd_q[2*CB-1:CB];
	assign rd_y   = st_rd_q[CB-1:0];

	assign dax_adj  = (da_x_q == '0 && da_y_q == '0) ? D'(1) : da_x_q;
	assign dbx_adj  = (db_x_q == '0 && db_y_q == '0) ? D'(1) : db_x_q;
	assign prod_ext = {prod_q[PW-1], prod_q};
	assign lb       = u_q + prod_ext;
	assign cw_flat  = (t_q <= prod_ext);

	always_comb begin
		pr_done = 1'b0;
		pr_res  = 1'b0;
		if (state_q == S_PR2 && t_q != prod_ext) begin
			pr_done = 1'b1;
			pr_res  = (t_q > prod_ext);
		end else if (state_q == S_PR6) begin
			pr_done = 1'b1;
			pr_res  = (dax_adj > 0) ? (t_q < lb) : (t_q > lb);
		end
	end

	always_comb begin
		st_ra = '0;
		so_ra = '0;
		hs_ra = '0;
		unique case (state_q)
			S_AN_RD:   st_ra = ii_q[IW-1:0];
			S_SO_NEXT: st_ra = ii_q[IW-1:0];
			S_SO_J:    so_ra = IW'(jj_q - CW'(1));
			S_SO_IDX:  st_ra = so_rd_q;
			S_SC_NEXT: so_ra = ii_q[IW-1:0];
			S_SC_NIDX: st_ra = so_rd_q;
			S_SC_TEST: hs_ra = IW'(depth_q - CW'(2));
			S_SC_PIDX: st_ra = hs_rd_q;
			S_SC_P:    hs_ra = IW'(depth_q - CW'(1));
			S_SC_CIDX: st_ra = hs_rd_q;
			S_EM_RD:   hs_ra = ii_q[IW-1:0];
			S_EM_IDX:  st_ra = hs_rd_q;
			default:   st_ra = '0;
		endcase
	end

	always_comb begin
		so_we = 1'b0;
		so_wa = jj_q[IW-1:0];
		so_wd = ii_q[IW-1:0];
		hs_we = 1'b0;
		hs_wa = depth_q[IW-1:0];
		hs_wd = nidx_q;
		if (state_q == S_SO_J && jj_q == '0) begin
			so_we = 1'b1;
		end else if (pr_done) begin
			so_we = 1'b1;
			if (pr_res) begin
				so_wd = bidx_q;
			end
		end
		if (state_q == S_SC_INIT) begin
			hs_we = 1'b1;
			hs_wa = '0;
			hs_wd = anchor_q;
		end else if (state_q == S_SC_TEST && depth_q < CW'(2)) begin
			hs_we = 1'b1;
		end else if (state_q == S_SC_M2 && !cw_flat) begin
			hs_we = 1'b1;
		end
	end

	always_comb begin
		unique case (state_q)
			S_PR0:   begin opa = dax_adj; opb = db_y_q;  end
			S_PR1:   begin opa = da_y_q;  opb = dbx_adj; end
			S_PR2:   begin opa = da_x_q;  opb = da_x_q;  end
			S_PR3:   begin opa = da_y_q;  opb = da_y_q;  end
			S_PR4:   begin opa = db_x_q;  opb = db_x_q;  end
			S_PR5:   begin opa = db_y_q;  opb = db_y_q;  end
			S_SC_M1: begin opa = da_y_q;  opb = db_x_q;  end
			default: begin opa = da_x_q;  opb = db_y_q;  end
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (in_acc && count_q < CW'(MAX_POINTS)) begin
			store_mem[count_q[IW-1:0]] <= {point_x, point_y};
		end
		st_rd_q <= store_mem[st_ra];
		if (so_we) begin
			sort_mem[so_wa] <= so_wd;
		end
		so_rd_q <= sort_mem[so_ra];
		if (hs_we) begin
			stack_mem[hs_wa] <= hs_wd;
		end
		hs_rd_q <= stack_mem[hs_ra];
		prod_q  <= opa * opb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_LOAD;
			count_q        <= '0;
			ovf_q          <= 1'b0;
			out_valid      <= 1'b0;
			ii_q           <= '0;
			nn_q           <= '0;
			jj_q           <= '0;
			depth_q        <= '0;
			anchor_q       <= '0;
			bidx_q         <= '0;
			nidx_q         <= '0;
			apx_q          <= '0;
			apy_q          <= '0;
			qx_q           <= '0;
			qy_q           <= '0;
			px_q           <= '0;
			py_q           <= '0;
			da_x_q         <= '0;
			da_y_q         <= '0;
			db_x_q         <= '0;
			db_y_q         <= '0;
			t_q            <= '0;
			u_q            <= '0;
			vertex_x       <= '0;
			vertex_y       <= '0;
			vertex_number  <= '0;
			final_vertex   <= 1'b0;
			dropped_points <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (valid) begin
						if (count_q < CW'(MAX_POINTS)) begin
							count_q <= count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (set_end) begin
							ii_q    <= '0;
							state_q <= S_AN_RD;
						end
					end
				end
				S_AN_RD: state_q <= S_AN_CMP;
				S_AN_CMP: begin
					if (ii_q == '0 || rd_y < apy_q || (rd_y == apy_q && rd_x < apx_q)) begin
						anchor_q <= ii_q[IW-1:0];
						apx_q    <= rd_x;
						apy_q    <= rd_y;
					end
					if (ii_q + CW'(1) == count_q) begin
						ii_q    <= '0;
						nn_q    <= '0;
						state_q <= S_SO_NEXT;
					end else begin
						ii_q    <= ii_q + CW'(1);
						state_q <= S_AN_RD;
					end
				end
				S_SO_NEXT: begin
					if (ii_q == count_q) begin
						state_q <= S_SC_INIT;
					end else if (ii_q[IW-1:0] == anchor_q) begin
						ii_q <= ii_q + CW'(1);
					end else begin
						jj_q    <= nn_q;
						state_q <= S_SO_Q;
					end
				end
				S_SO_Q: begin
					qx_q    <= rd_x;
					qy_q    <= rd_y;
					state_q <= S_SO_J;
				end
				S_SO_J: begin
					if (jj_q == '0) begin
						nn_q    <= nn_q + CW'(1);
						ii_q    <= ii_q + CW'(1);
						state_q <= S_SO_NEXT;
					end else begin
						state_q <= S_SO_IDX;
					end
				end
				S_SO_IDX: begin
					bidx_q  <= so_rd_q;
					state_q <= S_SO_B;
				end
				S_SO_B: begin
					da_x_q  <= {qx_q[CB-1], qx_q} - {apx_q[CB-1], apx_q};
					da_y_q  <= {qy_q[CB-1], qy_q} - {apy_q[CB-1], apy_q};
					db_x_q  <= {rd_x[CB-1], rd_x} - {apx_q[CB-1], apx_q};
					db_y_q  <= {rd_y[CB-1], rd_y} - {apy_q[CB-1], apy_q};
					state_q <= S_PR0;
				end
				S_PR0: state_q <= S_PR1;
				S_PR1: begin
					t_q     <= prod_ext;
					state_q <= S_PR2;
				end
				S_PR2, S_PR6: begin
					if (pr_done) begin
						if (pr_res) begin
							jj_q    <= jj_q - CW'(1);
							state_q <= S_SO_J;
						end else begin
							nn_q    <= nn_q + CW'(1);
							ii_q    <= ii_q + CW'(1);
							state_q <= S_SO_NEXT;
						end
					end else begin
						state_q <= S_PR3;
					end
				end
				S_PR3: begin
					t_q     <= prod_ext;
					state_q <= S_PR4;
				end
				S_PR4: begin
					t_q     <= t_q + prod_ext;
					state_q <= S_PR5;
				end
				S_PR5: begin
					u_q     <= prod_ext;
					state_q <= S_PR6;
				end
				S_SC_INIT: begin
					depth_q <= CW'(1);
					ii_q    <= '0;
					state_q <= S_SC_NEXT;
				end
				S_SC_NEXT: begin
					if (ii_q == nn_q) begin
						ii_q    <= '0;
						state_q <= S_EM_RD;
					end else begin
						state_q <= S_SC_NIDX;
					end
				end
				S_SC_NIDX: begin
					nidx_q  <= so_rd_q;
					state_q <= S_SC_N;
				end
				S_SC_N: begin
					qx_q    <= rd_x;
					qy_q    <= rd_y;
					state_q <= S_SC_TEST;
				end
				S_SC_TEST: begin
					if (depth_q < CW'(2)) begin
						depth_q <= depth_q + CW'(1);
						ii_q    <= ii_q + CW'(1);
						state_q <= S_SC_NEXT;
					end else begin
						state_q <= S_SC_PIDX;
					end
				end
				S_SC_PIDX: state_q <= S_SC_P;
				S_SC_P: begin
					px_q    <= rd_x;
					py_q    <= rd_y;
					state_q <= S_SC_CIDX;
				end
				S_SC_CIDX: state_q <= S_SC_C;
				S_SC_C: begin
					da_x_q  <= {rd_x[CB-1], rd_x} - {px_q[CB-1], px_q};
					da_y_q  <= {rd_y[CB-1], rd_y} - {py_q[CB-1], py_q};
					db_x_q  <= {qx_q[CB-1], qx_q} - {rd_x[CB-1], rd_x};
					db_y_q  <= {qy_q[CB-1], qy_q} - {rd_y[CB-1], rd_y};
					state_q <= S_SC_M0;
				end
				S_SC_M0: state_q <= S_SC_M1;
				S_SC_M1: begin
					t_q     <= prod_ext;
					state_q <= S_SC_M2;
				end
				S_SC_M2: begin
					if (cw_flat) begin
						depth_q <= depth_q - CW'(1);
						state_q <= S_SC_TEST;
					end else begin
						depth_q <= depth_q + CW'(1);
						ii_q    <= ii_q + CW'(1);
						state_q <= S_SC_NEXT;
					end
				end
				S_EM_RD:  state_q <= S_EM_IDX;
				S_EM_IDX: state_q <= S_EM_DATA;
				S_EM_DATA: begin
					vertex_x       <= rd_x;
					vertex_y       <= rd_y;
					vertex_number  <= VNUM_BITS'(ii_q);
					final_vertex   <= (ii_q + CW'(1) == depth_q);
					dropped_points <= ovf_q;
					out_valid      <= 1'b1;
					state_q        <= S_EM_WAIT;
				end
				S_EM_WAIT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						if (final_vertex) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							ii_q    <= ii_q + CW'(1);
							state_q <= S_EM_RD;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule
